// ===== hw/rtl/jlnq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jlnq_pkg;

  // Character codes used by the scanner and the emitter.
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Threshold register width and its value after reset.
  localparam int unsigned THR_W = 5;
  localparam logic [THR_W-1:0] THR_RESET = 5'd19;

  // Output plan for one input transaction, in emission order:
  // opening quote, held digits, the input byte, closing quote.
  typedef struct packed {
    logic q1;
    logic emit_c;
    logic q2;
    logic last;
  } plan_t;

  // Emitter sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_Q1   = 5'b00010,
    ST_HELD = 5'b00100,
    ST_BYTE = 5'b01000,
    ST_Q2   = 5'b10000
  } emit_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/jlnq_digit_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jlnq_digit_store #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 18,
  parameter int unsigned IW    = 5
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [IW-1:0]    rd_addr,
  output logic [WIDTH-1:0]      rd_data
);

  // Held digit values; contents are only read after being written in the run.
  logic [WIDTH-1:0] digit_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; a read of the address written at the same edge
  // returns the new data.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= digit_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/jlnq_emitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jlnq_emitter
  import jlnq_pkg::*;
#(
  parameter int unsigned RW = 5,
  parameter int unsigned IW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire plan_t         plan,
  input  wire logic [RW-1:0] held_cnt,
  input  wire logic [7:0]    in_byte,
  output logic               idle,
  output logic [IW-1:0]      rd_addr,
  input  wire logic [3:0]    rd_data,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast
);

  emit_state_t   state_r, state_nxt;
  plan_t         plan_r;
  logic [RW-1:0] cnt_r;
  logic [RW-1:0] idx_r, idx_nxt;
  logic [7:0]    byte_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  logic          emit;
  logic          held_done;
  emit_state_t   after_held, after_q1, after_byte, first_st, cur_next;

  assign idle    = (state_r == ST_IDLE);
  // The store read is registered, so it is addressed with the next index.
  assign rd_addr = idx_nxt[IW-1:0];
  assign emit    = !idle && (!out_valid_r || out_tready);
  assign held_done = (idx_r == cnt_r - 1'b1);

  // Successor segments of the stored plan.
  always_comb begin
    after_byte = plan_r.q2 ? ST_Q2 : ST_IDLE;
    after_held = plan_r.emit_c ? ST_BYTE : after_byte;
    after_q1   = (cnt_r != '0) ? ST_HELD : after_held;
  end

  // First segment of a freshly started plan.
  always_comb begin
    if (plan.q1) begin
      first_st = ST_Q1;
    end else if (held_cnt != '0) begin
      first_st = ST_HELD;
    end else if (plan.emit_c) begin
      first_st = ST_BYTE;
    end else if (plan.q2) begin
      first_st = ST_Q2;
    end else begin
      first_st = ST_IDLE;
    end
  end

  // Sequencer: one output byte per cycle while the output register drains.
  always_comb begin
    cur_next      = state_r;
    out_byte_nxt  = out_byte_r;
    idx_nxt       = idx_r;
    case (state_r)
      ST_Q1: begin
        cur_next     = after_q1;
        out_byte_nxt = CHAR_QUOTE;
      end
      ST_HELD: begin
        cur_next     = held_done ? after_held : ST_HELD;
        out_byte_nxt = CHAR_ZERO | {4'h0, rd_data};
        idx_nxt      = held_done ? '0 : idx_r + 1'b1;
      end
      ST_BYTE: begin
        cur_next     = after_byte;
        out_byte_nxt = byte_r;
      end
      ST_Q2: begin
        cur_next     = ST_IDLE;
        out_byte_nxt = CHAR_QUOTE;
      end
      default: begin
        cur_next = ST_IDLE;
      end
    endcase

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    if (idle) begin
      if (start) begin
        state_nxt = first_st;
        idx_nxt   = '0;
      end
    end else if (emit) begin
      state_nxt     = cur_next;
      out_valid_nxt = 1'b1;
      out_last_nxt  = plan_r.last && (cur_next == ST_IDLE);
    end
    if (!emit) begin
      out_byte_nxt = out_byte_r;
      out_last_nxt = out_last_r;
      if (!idle) begin
        idx_nxt = idx_r;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Plan and payload registers.
  always_ff @(posedge clk) begin
    if (idle && start) begin
      plan_r <= plan;
      cnt_r  <= held_cnt;
      byte_r <= in_byte;
    end
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  // The held index stays inside the planned count.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HELD) |-> (idx_r < cnt_r))
    else $error("held digit index beyond planned count");

  // A plan is never started while another is still being emitted.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !idle) |=> 1'b0)
    else $error("new transaction started while emitter busy");

  // A byte marked last closes its plan, so the sequencer goes idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && plan_r.last && (cur_next == ST_IDLE)) |=> (idle && out_tlast))
    else $error("final byte emitted without closing the plan");

endmodule

`default_nettype wire

// ===== hw/rtl/json_long_number_quoter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// The first output byte of a transaction passes through the sequencer state and the output register.
// A transaction emits 0 to MAX_THRESHOLD+2 output bytes, stepped out by the emitter sequencer
// through the held digit store.
// A digit held back without output leaves the core idle; in_tready is low while bytes are emitted.
// Reset (synchronous, rst_n low) clears string and run state, sets the threshold to 19,
// and leaves the digit store uncleared.
module json_long_number_quoter_core
  import jlnq_pkg::*;
#(
  parameter int unsigned MAX_THRESHOLD = 19
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // in_tdata: [7:0] in_byte
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,
  input  wire logic             in_tlast,
  // out_tdata: [7:0] out_byte
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tlast,
  input  wire logic             cfg_wr_en,
  input  wire logic [THR_W-1:0] cfg_wr_data
);

  localparam int unsigned RW    = $clog2(MAX_THRESHOLD + 1);
  localparam int unsigned DEPTH = MAX_THRESHOLD - 1;
  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [THR_W-1:0] quote_thr_r;
  logic             inside_r, inside_nxt;
  logic [RW-1:0]    rl_r, rl_nxt, rl_inc;
  logic [RW-1:0]    thr_r, thr_nxt, thr_clamp, thr_use;
  logic             accept, is_digit, idle;
  plan_t            plan;
  logic [RW-1:0]    held_cnt;
  logic             wr_en;
  logic [IW-1:0]    rd_addr;
  logic [3:0]       rd_data;

  assign in_tready = idle;
  assign accept    = in_tvalid && in_tready;
  assign is_digit  = (in_tdata >= CHAR_ZERO) && (in_tdata <= CHAR_NINE);

  // Threshold clamped into 1..MAX_THRESHOLD; it is latched when no run is open.
  always_comb begin
    if (quote_thr_r == '0) begin
      thr_clamp = RW'(1);
    end else if ({1'b0, quote_thr_r} > (THR_W + 1)'(MAX_THRESHOLD)) begin
      thr_clamp = RW'(MAX_THRESHOLD);
    end else begin
      thr_clamp = RW'(quote_thr_r);
    end
    thr_use = (rl_r == '0) ? thr_clamp : thr_r;
    thr_nxt = thr_use;
  end

  // Scanner: classify the byte and build the output plan for it.
  always_comb begin
    plan       = '0;
    held_cnt   = '0;
    wr_en      = 1'b0;
    rl_nxt     = rl_r;
    inside_nxt = inside_r;
    rl_inc     = rl_r + 1'b1;
    if (!inside_r && is_digit) begin
      if (rl_r < thr_use) begin
        rl_nxt = rl_inc;
        if (rl_inc == thr_use) begin
          plan.q1     = 1'b1;
          held_cnt    = thr_use - 1'b1;
          plan.emit_c = 1'b1;
          plan.q2     = in_tlast;
        end else begin
          wr_en = 1'b1;
          if (in_tlast) begin
            held_cnt = rl_inc;
          end
        end
      end else begin
        plan.emit_c = 1'b1;
        plan.q2     = in_tlast;
      end
    end else begin
      if (rl_r != '0) begin
        if (rl_r >= thr_use) begin
          plan.q1 = 1'b1;
        end else begin
          held_cnt = rl_r;
        end
      end
      plan.emit_c = 1'b1;
      rl_nxt      = '0;
      if (in_tdata == CHAR_QUOTE) begin
        inside_nxt = ~inside_r;
      end
    end
    plan.last = in_tlast;
    if (in_tlast) begin
      rl_nxt     = '0;
      inside_nxt = 1'b0;
    end
  end

  // Configuration and scanner state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_thr_r <= THR_RESET;
      inside_r    <= 1'b0;
      rl_r        <= '0;
      thr_r       <= RW'(MAX_THRESHOLD);
    end else begin
      if (cfg_wr_en) begin
        quote_thr_r <= cfg_wr_data;
      end
      if (accept) begin
        inside_r <= inside_nxt;
        rl_r     <= rl_nxt;
        thr_r    <= thr_nxt;
      end
    end
  end

  jlnq_digit_store #(
    .WIDTH (4),
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && wr_en),
    .wr_addr (rl_r[IW-1:0]),
    .wr_data (in_tdata[3:0]),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  jlnq_emitter #(
    .RW (RW),
    .IW (IW)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept),
    .plan       (plan),
    .held_cnt   (held_cnt),
    .in_byte    (in_tdata),
    .idle       (idle),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
